[rtl/flru_pkg.sv]
package flru_pkg;

  localparam int unsigned ENTRIES_DEF   = 8;
  localparam int unsigned KEY_WIDTH_DEF = 8;

  localparam int unsigned USES_W  = 16;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [USES_W-1:0]  USES_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_LRU  = 2'd1,
    POL_LFU  = 2'd2,
    POL_RSVD = 2'd3
  } policy_t;

  typedef enum logic {
    MODE_ACCESS = 1'b0,
    MODE_FLUSH  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_HOLD
  } state_t;

endpackage

[rtl/fifo_lru_lfu_replacement_unit.sv]
// Fully associative tag store with a FIFO, LRU or LFU replacement rule.
//
// Input channel (in_*): one beat per lookup. in_tuser carries the mode
// (access or flush), in_tdata the key. Result channel (out_*): exactly one
// beat per input beat, in order: hit flag, slot, eviction flag and key,
// use count of the entry and the two saturating hit / miss totals.
// cfg_wr_en / cfg_wr_data load the 2-bit policy register; the user must
// write it only while idle, as the block does not enforce this.
// Sequence: an access walks the slots twice with one shared compare unit:
// a scan pass (match, free slot, victim) over all ENTRIES slots, a
// decision state, then an update pass over the slots that ages entries
// and writes the chosen slot, then a hold state that loads the result.
// A flush skips both passes and goes straight to the hold state. No new
// beat is taken until the hold state has loaded the result; in_tready
// returns as that result is offered.
// in_tready is high only while the sequencer is idle; the next beat may be
// accepted while a result waits. A result still stalled when the next is
// ready holds the sequencer in its last state until the register frees.
// Reset (rst_n low, synchronous) clears valid bits, occupancy, totals and
// the policy (FIFO); stored keys, counts and ages are left as they are.
module fifo_lru_lfu_replacement_unit #(
  parameter int unsigned ENTRIES   = flru_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_WIDTH = flru_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,  // policy
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] key
  input  logic [0:0]  in_tuser,     // [0] mode
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata     // [0] hit, [3:1] slot, [4] evicted,
                                    // [12:5] evicted_key, [28:13] use_count,
                                    // [60:29] hit_total, [92:61] miss_total,
                                    // [95:93] zero
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned US_W  = flru_pkg::USES_W;
  localparam int unsigned TOT_W = flru_pkg::TOTAL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(ENTRIES);

  // slot store
  logic [KEY_WIDTH-1:0] key_mem [ENTRIES];
  logic [US_W-1:0]      uses_mem[ENTRIES];
  logic [IDX_W-1:0]     age_mem [ENTRIES];
  logic [ENTRIES-1:0]   valid_r;

  logic [OCC_W-1:0] occ_r;
  logic [TOT_W-1:0] hits_r, misses_r;
  flru_pkg::policy_t policy_r;
  flru_pkg::state_t  state_r, state_nxt;

  logic [IDX_W-1:0]     idx_r;
  logic [KEY_WIDTH-1:0] key_r;

  // scan results
  logic                 match_r;
  logic [IDX_W-1:0]     match_idx_r, match_age_r;
  logic                 free_r;
  logic [IDX_W-1:0]     free_idx_r;
  logic                 vic_r;
  logic [IDX_W-1:0]     vic_idx_r, vic_age_r;
  logic [US_W-1:0]      vic_uses_r;
  logic [KEY_WIDTH-1:0] vic_key_r;

  // decision
  logic                 hit_r, evict_r, recent_r, fill_r;
  logic [IDX_W-1:0]     slot_r, old_age_r;
  logic [KEY_WIDTH-1:0] evkey_r;
  logic [US_W-1:0]      use_r;

  // output register
  logic        out_valid_r;
  logic [95:0] out_data_r;

  // sequencer controls
  logic accept, scan_last, upd_last, can_load;
  logic is_lru, is_lfu;

  // current entry through the shared port
  logic [KEY_WIDTH-1:0] cur_key;
  logic [US_W-1:0]      cur_uses;
  logic [IDX_W-1:0]     cur_age;
  logic                 cur_valid, vic_better;

  assign is_lru = (policy_r == flru_pkg::POL_LRU);
  assign is_lfu = (policy_r == flru_pkg::POL_LFU);

  assign cur_key   = key_mem[idx_r];
  assign cur_uses  = uses_mem[idx_r];
  assign cur_age   = age_mem[idx_r];
  assign cur_valid = valid_r[idx_r];

  // shared victim compare
  always_comb begin
    if (!vic_r) begin
      vic_better = 1'b1;
    end else if (is_lfu) begin
      vic_better = (cur_uses < vic_uses_r) ||
                   ((cur_uses == vic_uses_r) && (cur_age > vic_age_r));
    end else begin
      vic_better = (cur_age > vic_age_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flru_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == flru_pkg::MODE_FLUSH) ? flru_pkg::ST_HOLD
                                                            : flru_pkg::ST_SCAN;
        end
      end
      flru_pkg::ST_SCAN:   if (idx_r == LAST_IDX) state_nxt = flru_pkg::ST_DECIDE;
      flru_pkg::ST_DECIDE: state_nxt = flru_pkg::ST_UPDATE;
      flru_pkg::ST_UPDATE: if (idx_r == LAST_IDX) state_nxt = flru_pkg::ST_HOLD;
      flru_pkg::ST_HOLD:   if (!out_valid_r || out_tready) state_nxt = flru_pkg::ST_IDLE;
      default:             state_nxt = flru_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = (state_r == flru_pkg::ST_IDLE);
    accept    = in_tready && in_tvalid;
    scan_last = (state_r == flru_pkg::ST_SCAN)   && (idx_r == LAST_IDX);
    upd_last  = (state_r == flru_pkg::ST_UPDATE) && (idx_r == LAST_IDX);
    can_load  = (state_r == flru_pkg::ST_HOLD)   && (!out_valid_r || out_tready);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flru_pkg::ST_IDLE;
      policy_r    <= flru_pkg::POL_FIFO;
      valid_r     <= '0;
      occ_r       <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) policy_r <= flru_pkg::policy_t'(cfg_wr_data);

      if (accept || scan_last || upd_last) begin
        idx_r <= '0;
      end else if (state_r == flru_pkg::ST_SCAN || state_r == flru_pkg::ST_UPDATE) begin
        idx_r <= idx_r + 1'b1;
      end

      if (accept && in_tuser[0] == flru_pkg::MODE_FLUSH) begin
        valid_r  <= '0;
        occ_r    <= '0;
        hits_r   <= '0;
        misses_r <= '0;
      end

      if (state_r == flru_pkg::ST_DECIDE) begin
        if (match_r) begin
          if (hits_r != flru_pkg::TOTAL_MAX) hits_r <= hits_r + 1'b1;
        end else begin
          if (misses_r != flru_pkg::TOTAL_MAX) misses_r <= misses_r + 1'b1;
          if (occ_r < FULL_OCC) occ_r <= occ_r + 1'b1;
        end
      end

      if (state_r == flru_pkg::ST_UPDATE && idx_r == slot_r && !hit_r) begin
        valid_r[idx_r] <= 1'b1;
      end

      if (can_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      flru_pkg::ST_IDLE: begin
        if (accept) begin
          key_r   <= KEY_WIDTH'(in_tdata);
          match_r <= 1'b0;
          free_r  <= 1'b0;
          vic_r   <= 1'b0;
          // flush result is all zero
          hit_r   <= 1'b0;
          evict_r <= 1'b0;
          slot_r  <= '0;
          evkey_r <= '0;
          use_r   <= '0;
        end
      end
      flru_pkg::ST_SCAN: begin
        if (cur_valid) begin
          if (!match_r && cur_key == key_r) begin
            match_r     <= 1'b1;
            match_idx_r <= idx_r;
            match_age_r <= cur_age;
          end
          if (vic_better) begin
            vic_r      <= 1'b1;
            vic_idx_r  <= idx_r;
            vic_age_r  <= cur_age;
            vic_uses_r <= cur_uses;
            vic_key_r  <= cur_key;
          end
        end else if (!free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= idx_r;
        end
      end
      flru_pkg::ST_DECIDE: begin
        hit_r     <= match_r;
        evict_r   <= 1'b0;
        evkey_r   <= '0;
        recent_r  <= 1'b0;
        fill_r    <= 1'b0;
        old_age_r <= '0;
        if (match_r) begin
          slot_r    <= match_idx_r;
          recent_r  <= is_lru || is_lfu;
          old_age_r <= match_age_r;
        end else if (occ_r >= FULL_OCC) begin
          slot_r    <= vic_idx_r;
          evict_r   <= 1'b1;
          evkey_r   <= vic_key_r;
          recent_r  <= 1'b1;
          old_age_r <= vic_age_r;
        end else begin
          slot_r <= free_r ? free_idx_r : '0;
          fill_r <= 1'b1;
        end
      end
      flru_pkg::ST_UPDATE: begin
        if (idx_r == slot_r) begin
          if (!hit_r) begin
            key_mem[idx_r]  <= key_r;
            uses_mem[idx_r] <= US_W'(1);
            age_mem[idx_r]  <= '0;
            use_r           <= US_W'(1);
          end else if (is_lfu) begin
            if (cur_uses != flru_pkg::USES_MAX) begin
              uses_mem[idx_r] <= cur_uses + 1'b1;
              use_r           <= cur_uses + 1'b1;
            end else begin
              use_r <= cur_uses;
            end
            age_mem[idx_r] <= '0;
          end else begin
            if (is_lru) age_mem[idx_r] <= '0;
            use_r <= cur_uses;
          end
        end else if (cur_valid) begin
          if (fill_r || (recent_r && cur_age < old_age_r)) begin
            age_mem[idx_r] <= cur_age + 1'b1;
          end
        end
      end
      flru_pkg::ST_HOLD: begin
        if (can_load) begin
          out_data_r <= {3'b000, misses_r, hits_r, use_r, 8'(evkey_r), evict_r,
                         3'(slot_r), hit_r};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[verif/fifo_lru_lfu_replacement_unit_tb.sv]
`timescale 1ns / 1ps

module fifo_lru_lfu_replacement_unit_tb;

  localparam int unsigned SLOTS     = flru_pkg::ENTRIES_DEF;
  // accept-to-result of one access, plus some slack
  localparam int unsigned SETTLE    = 2 * SLOTS + 3 + 8;
  localparam int unsigned MAX_NOTES = 10;

  // one lookup request as it travels on the input channel
  typedef struct {
    flru_pkg::mode_t mode;
    logic [7:0]      key;
  } lookup_req_t;

  // result beat; declared top-down so that bit 0 is hit, matching out_tdata
  typedef struct packed {
    logic [31:0] miss_total;
    logic [31:0] hit_total;
    logic [15:0] use_count;
    logic [7:0]  evicted_key;
    logic        evicted;
    logic [2:0]  slot;
    logic        hit;
  } lookup_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = flru_pkg::POL_FIFO;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic [0:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [95:0] out_tdata;

  fifo_lru_lfu_replacement_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] key
    .in_tuser   (in_tuser),   // [0] mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [0] hit, [3:1] slot, [4] evicted, [12:5] evicted_key,
                              // [28:13] use_count, [60:29] hit_total,
                              // [92:61] miss_total, [95:93] zero
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Tag store shadow: the predictor's own copy of slots, ranks and totals
  // ---------------------------------------------------------------------
  flru_pkg::policy_t active_policy = flru_pkg::POL_FIFO;  // mirrors the policy register
  logic        slot_used [SLOTS];
  logic [7:0]  slot_key  [SLOTS];
  logic [15:0] slot_uses [SLOTS];
  int unsigned slot_rank [SLOTS];         // 0 = most recent
  int unsigned fill_level;
  logic [31:0] hits_so_far;
  logic [31:0] misses_so_far;

  lookup_req_t lookup_reqs [$];   // waiting for the driver
  lookup_t     lookups_due [$];   // predicted, waiting for their result beat

  int unsigned fault_count = 0;
  int unsigned in_beats    = 0;   // written by the monitor only
  int unsigned out_beats   = 0;

  // flush and reset share this: valid bits, fill level and totals go
  function automatic void forget_store();
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    fill_level    = 0;
    hits_so_far   = '0;
    misses_so_far = '0;
  endfunction

  // move slot s to the front; anything that was younger ages by one
  function automatic void promote(int unsigned s);
    int unsigned old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && i != s && slot_rank[i] < old_rank) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  // oldest entry, or for LFU lowest count with the oldest breaking ties
  function automatic int unsigned victim_slot(bit by_count);
    int unsigned best;
    bit          seen;
    best = 0;
    seen = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!slot_used[i]) continue;
      if (!seen) begin
        best = i;
        seen = 1'b1;
      end else if (by_count) begin
        if (slot_uses[i] < slot_uses[best] ||
            (slot_uses[i] == slot_uses[best] && slot_rank[i] > slot_rank[best]))
          best = i;
      end else if (slot_rank[i] > slot_rank[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // advances the shadow store by one request and returns the result beat
  function automatic lookup_t predict_lookup(flru_pkg::mode_t mode, logic [7:0] key);
    lookup_t     res;
    int unsigned s;
    bit          found;
    res   = '0;
    s     = 0;
    found = 1'b0;
    if (mode == flru_pkg::MODE_FLUSH) begin
      forget_store();
      return res;
    end
    for (int i = 0; i < SLOTS; i++)
      if (!found && slot_used[i] && slot_key[i] == key) begin
        s     = i;
        found = 1'b1;
      end
    if (found) begin
      res.hit = 1'b1;
      if (hits_so_far != flru_pkg::TOTAL_MAX) hits_so_far++;
      if (active_policy == flru_pkg::POL_LFU) begin
        if (slot_uses[s] != flru_pkg::USES_MAX) slot_uses[s]++;
        promote(s);
      end else if (active_policy == flru_pkg::POL_LRU) begin
        promote(s);
      end
    end else begin
      if (misses_so_far != flru_pkg::TOTAL_MAX) misses_so_far++;
      if (fill_level >= SLOTS) begin
        s               = victim_slot(active_policy == flru_pkg::POL_LFU);
        res.evicted     = 1'b1;
        res.evicted_key = slot_key[s];
        promote(s);
      end else begin
        // lowest free slot; every resident entry gets one older
        found = 1'b0;
        for (int i = 0; i < SLOTS; i++)
          if (!found && !slot_used[i]) begin
            s     = i;
            found = 1'b1;
          end
        for (int i = 0; i < SLOTS; i++)
          if (slot_used[i]) slot_rank[i]++;
        fill_level++;
      end
      slot_used[s] = 1'b1;
      slot_key[s]  = key;
      slot_uses[s] = 16'd1;
      slot_rank[s] = 0;
    end
    res.slot       = s[2:0];
    res.use_count  = slot_uses[s];
    res.hit_total  = hits_so_far;
    res.miss_total = misses_so_far;
    return res;
  endfunction

  function automatic void note_fault(string what);
    if (fault_count < MAX_NOTES) $display("%0t ns: %s", $time, what);
    fault_count++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_fault($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
  endfunction

  // runs of back-to-back beats alternate with runs of random pauses per beat
  function automatic int unsigned draw_pause(inout int unsigned run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      quiet    = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge. Result beat is
  // checked before the same edge's request is predicted, as the result
  // can only belong to an older request.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    lookup_t got;
    lookup_t want;
    if (!rst_n) begin
      forget_store();
    end else begin
      if (out_tvalid && out_tready) begin
        out_beats++;
        got = out_tdata[92:0];
        if (lookups_due.size() == 0) begin
          note_fault($sformatf("result beat with nothing outstanding: 0x%0h", out_tdata));
        end else begin
          want = lookups_due.pop_front();
          check_field("hit",         want.hit,         got.hit);
          check_field("slot",        want.slot,        got.slot);
          check_field("evicted",     want.evicted,     got.evicted);
          check_field("evicted_key", want.evicted_key, got.evicted_key);
          check_field("use_count",   want.use_count,   got.use_count);
          check_field("hit_total",   want.hit_total,   got.hit_total);
          check_field("miss_total",  want.miss_total,  got.miss_total);
          check_field("tdata pad",   3'b000,           out_tdata[95:93]);
        end
      end
      if (in_tvalid && in_tready) begin
        in_beats++;
        lookups_due.push_back(predict_lookup(flru_pkg::mode_t'(in_tuser[0]), in_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: one beat at a time from lookup_reqs, changed at falling edges.
  // in_tvalid gets exactly one update per edge so a back-to-back beat
  // keeps it high.
  // ---------------------------------------------------------------------
  int unsigned in_seen     = 0;
  int unsigned in_hold     = 0;
  int unsigned in_run_left = 0;
  bit          in_quiet    = 1'b0;

  always @(negedge clk) begin : feed
    lookup_req_t req;
    logic        next_valid;
    next_valid = in_tvalid;
    if (in_beats != in_seen) begin
      in_seen    = in_beats;
      next_valid = 1'b0;
      in_hold    = draw_pause(in_run_left, in_quiet);
    end
    if (!next_valid && rst_n) begin
      if (in_hold > 0) begin
        in_hold--;
      end else if (lookup_reqs.size() > 0) begin
        req        = lookup_reqs.pop_front();
        in_tuser   <= req.mode;
        in_tdata   <= req.key;
        next_valid = 1'b1;
      end
    end
    in_tvalid <= next_valid;
  end

  // receiver: stall count only runs down while a result is on offer,
  // so stalls land on presented beats rather than dead time
  int unsigned out_seen     = 0;
  int unsigned out_hold     = 0;
  int unsigned out_run_left = 0;
  bit          out_quiet    = 1'b0;

  always @(negedge clk) begin : sink
    if (out_beats != out_seen) begin
      out_seen = out_beats;
      out_hold = draw_pause(out_run_left, out_quiet);
    end
    out_tready <= (out_hold == 0);
    if (out_tvalid && out_hold > 0) out_hold--;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic queue_lookup(flru_pkg::mode_t mode, logic [7:0] key);
    lookup_reqs.push_back('{mode: mode, key: key});
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain();
    while (lookup_reqs.size() != 0 || in_tvalid || lookups_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // policy only changes with the block idle
  task automatic set_policy(flru_pkg::policy_t pol);
    drain();
    @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= pol;
    active_policy = pol;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly hot keys from a small pool (skewed towards the first few, so
  // LFU counts spread out), some cold keys across the full range, rare flushes
  task automatic run_phase(flru_pkg::policy_t pol, int unsigned count, bit pause_midway);
    logic [7:0]  pool [16];
    int unsigned pool_n;
    int unsigned roll;
    int unsigned pick;
    set_policy(pol);
    pool_n = $urandom_range(6, 16);
    for (int i = 0; i < pool_n; i++) pool[i] = 8'($urandom_range(0, 255));
    for (int n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        queue_lookup(flru_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)));
      end else if (roll < 11) begin
        queue_lookup(flru_pkg::MODE_ACCESS, 8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, $urandom_range(0, pool_n - 1));
        queue_lookup(flru_pkg::MODE_ACCESS, pool[pick]);
      end
    end
  endtask

  initial begin : script
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // FIFO straight out of reset: flush on an empty store, key extremes,
    // a hit, fill to full, then eviction of the first-in key despite its hit
    queue_lookup(flru_pkg::MODE_FLUSH, 8'h5A);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h00);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'hFF);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h00);
    for (int k = 1; k <= 6; k++) queue_lookup(flru_pkg::MODE_ACCESS, k[7:0]);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h00);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'hAA);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h00);

    // LRU: a hit saves key 1, so the next oldest goes
    set_policy(flru_pkg::POL_LRU);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h01);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h7E);

    // LFU: counts climb, lowest count loses; flush then refill from slot 0
    set_policy(flru_pkg::POL_LFU);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h7E);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h7E);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'h81);
    queue_lookup(flru_pkg::MODE_FLUSH, 8'hFF);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'hFF);
    queue_lookup(flru_pkg::MODE_ACCESS, 8'hFF);

    // random phases across every policy value, reserved code included
    run_phase(flru_pkg::POL_LRU,  170, 1'b0);
    run_phase(flru_pkg::POL_LFU,  170, 1'b1);
    run_phase(flru_pkg::POL_RSVD, 140, 1'b0);
    run_phase(flru_pkg::POL_FIFO, 150, 1'b0);
    run_phase(flru_pkg::POL_LFU,  200, 1'b0);
    run_phase(flru_pkg::POL_LRU,  150, 1'b1);
    run_phase(flru_pkg::POL_FIFO, 120, 1'b0);
    run_phase(flru_pkg::POL_LFU,  180, 1'b0);

    drain();
    // stray beats would still be caught by the monitor here
    repeat (SETTLE) @(posedge clk);
    if (lookups_due.size() != 0)
      $display("%0d result beat(s) never arrived", lookups_due.size());

    if (fault_count == 0 && lookups_due.size() == 0) begin
      $display("fifo_lru_lfu_replacement_unit_tb: done, clean");
    end else begin
      $display("fifo_lru_lfu_replacement_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("fifo_lru_lfu_replacement_unit_tb: done, errors");
    $finish;
  end

endmodule
